// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define ASO_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define ASO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/aso_pkg.sv -----
// Shared constants and types of the actuator scale, offset and clip block.
package aso_pkg;

	localparam int MAX_ACTUATORS = 4096;
	localparam int TALLY_W       = 14;
	localparam int TALLY_CAP_I   = (2 * MAX_ACTUATORS > 16383) ? 16383 : 2 * MAX_ACTUATORS;
	localparam logic [TALLY_W-1:0] TALLY_CAP = TALLY_CAP_I[TALLY_W-1:0];

	localparam logic MODE_CODE  = 1'b0;
	localparam logic MODE_FIXED = 1'b1;

	localparam logic signed [31:0] SAT_POS = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SAT_NEG = 32'sh8000_0000;

	// result of the rounding and limit stage
	typedef struct packed {
		logic [31:0] cmd;
		logic [1:0]  events;
	} lim_res_t;

endpackage

// ----- rtl/core/aso_mul.sv -----
// Shared signed 32x32 multiplier with registered product.
module aso_mul import aso_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] op_a,
	input  logic signed [31:0] op_b,
	output logic signed [63:0] prod_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= op_a * op_b;
		end
	end

endmodule

// ----- rtl/core/aso_limit.sv -----
// Rounding to integer code in code mode, and min/max clamping with clip event count.
module aso_limit import aso_pkg::*; (
	input  logic               mode,
	input  logic signed [31:0] v,
	input  logic        [15:0] lo,
	input  logic        [15:0] hi,
	output lim_res_t           res
);

	logic signed [32:0] t;
	logic signed [16:0] code;
	logic signed [16:0] lo_c;
	logic signed [16:0] hi_c;
	logic signed [32:0] vx;
	logic signed [32:0] lq;
	logic signed [32:0] hq;
	logic               below;
	logic               above;

	// v + 0.5, then truncate toward zero
	assign t    = {v[31], v} + 33'sd32768;
	assign code = t[32:16] + {16'd0, t[32] & (|t[15:0])};
	assign lo_c = $signed({1'b0, lo});
	assign hi_c = $signed({1'b0, hi});

	assign vx = {v[31], v};
	assign lq = $signed({1'b0, lo, 16'd0});
	assign hq = $signed({1'b0, hi, 16'd0});

	always_comb begin
		if (mode == MODE_CODE) begin
			below = code < lo_c;
			above = code > hi_c;
		end else begin
			below = vx < lq;
			above = vx > hq;
		end
		res.events = {1'b0, below} + {1'b0, above};
		if (mode == MODE_CODE) begin
			res.cmd = {16'd0, code[15:0]};
			if (below) begin
				res.cmd = {16'd0, lo};
			end
			if (above) begin
				res.cmd = {16'd0, hi};
			end
		end else begin
			res.cmd = v;
			// limits of 32768 and up do not fit Q16.16
			if (below) begin
				res.cmd = lo[15] ? SAT_POS : {lo, 16'd0};
			end
			if (above) begin
				res.cmd = hi[15] ? SAT_POS : {hi, 16'd0};
			end
		end
	end

endmodule

// ----- rtl/core/actuator_scale_offset_clip.sv -----
// Top level: sequencer around one shared multiplier, clamp stage and frame tally.
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid/s_axis_tready    tdata 136b, tlast = frame_end
//  m_axis   out  m_axis_tvalid/m_axis_tready    tdata 48b,  tlast = frame_done
//  cfg      in   cfg_we                         cfg_wdata = output_mode
//
// An item steps through the MUL, ADD and CLIP states; with square_enable the second
// pass through the multiplier adds SQR and SQS before CLIP. Both passes use the one multiplier.
// s_axis_tready is high only while the sequencer is idle.
// A result waiting in the output register only stalls the clamp step.
// Reset clears mode, tally, sequencer and output valid.
module actuator_scale_offset_clip import aso_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// demand[31:0], gain[63:32], bias[95:64], square_enable[96],
	// code_min[112:97], code_max[128:113], zero pad[135:129]
	input  logic [135:0] s_axis_tdata,
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// command[31:0], clip_events[33:32], frame_clip_total[47:34]
	output logic [47:0]  m_axis_tdata,
	output logic         m_axis_tlast,
	input  logic         cfg_we,
	input  logic         cfg_wdata
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_ADD  = 3'd2;
	localparam logic [2:0] ST_SQR  = 3'd3;
	localparam logic [2:0] ST_SQS  = 3'd4;
	localparam logic [2:0] ST_CLIP = 3'd5;

	logic [2:0]          state_q;
	logic                mode_q;
	logic [TALLY_W-1:0]  tally_q;

	logic signed [31:0]  demand_q;
	logic signed [31:0]  gain_q;
	logic signed [31:0]  bias_q;
	logic                sq_q;
	logic [15:0]         lo_q;
	logic [15:0]         hi_q;
	logic                fend_q;
	logic signed [31:0]  v_q;

	logic                out_valid_q;
	logic [47:0]         out_data_q;
	logic                out_last_q;

	logic                accept;
	logic                out_free;
	logic                mul_en;
	logic signed [31:0]  mul_a;
	logic signed [31:0]  mul_b;
	logic signed [63:0]  prod_q;
	logic signed [48:0]  sum;
	logic signed [31:0]  sum_sat;
	logic signed [31:0]  sq_sat;
	lim_res_t            lim;
	logic [TALLY_W:0]    tally_sum;
	logic [TALLY_W-1:0]  tally_next;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign mul_en = (state_q == ST_MUL) || (state_q == ST_SQR);
	assign mul_a  = (state_q == ST_SQR) ? v_q : demand_q;
	assign mul_b  = (state_q == ST_SQR) ? v_q : gain_q;

	aso_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (prod_q)
	);

	// floor(p / 65536) + bias, saturated to int32
	assign sum = {prod_q[63], prod_q[63:16]} + {{17{bias_q[31]}}, bias_q};
	always_comb begin
		if (sum > 49'sh0_7FFF_FFFF) begin
			sum_sat = SAT_POS;
		end else if (sum < -49'sh0_8000_0000) begin
			sum_sat = SAT_NEG;
		end else begin
			sum_sat = sum[31:0];
		end
	end

	// square is never negative
	assign sq_sat = (|prod_q[63:47]) ? SAT_POS : prod_q[47:16];

	aso_limit u_limit (
		.mode (mode_q),
		.v    (v_q),
		.lo   (lo_q),
		.hi   (hi_q),
		.res  (lim)
	);

	assign tally_sum  = {1'b0, tally_q} + {{(TALLY_W - 1){1'b0}}, lim.events};
	assign tally_next = (tally_sum > {1'b0, TALLY_CAP}) ? TALLY_CAP : tally_sum[TALLY_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CODE;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tally_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_ADD;
				ST_ADD: state_q <= sq_q ? ST_SQR : ST_CLIP;
				ST_SQR: state_q <= ST_SQS;
				ST_SQS: state_q <= ST_CLIP;
				ST_CLIP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						tally_q     <= fend_q ? '0 : tally_next;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			demand_q <= s_axis_tdata[31:0];
			gain_q   <= s_axis_tdata[63:32];
			bias_q   <= s_axis_tdata[95:64];
			sq_q     <= s_axis_tdata[96];
			lo_q     <= s_axis_tdata[112:97];
			hi_q     <= s_axis_tdata[128:113];
			fend_q   <= s_axis_tlast;
		end
		if (state_q == ST_ADD) begin
			v_q <= sum_sat;
		end else if (state_q == ST_SQS) begin
			v_q <= sq_sat;
		end
		if (state_q == ST_CLIP && out_free) begin
			out_data_q <= {(fend_q ? tally_next : {TALLY_W{1'b0}}), lim.events, lim.cmd};
			out_last_q <= fend_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// ----- rtl/core/aso_checker.sv -----
// Port-level checker for the actuator scale, offset and clip block, with its bind.
`include "assert_macros.svh"

module aso_checker import aso_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [47:0]  m_axis_tdata,
	input logic         m_axis_tlast
);

	// a stalled result word stays offered
	`ASO_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result word dropped while stalled")
	// one word at a time: busy right after taking one
	`ASO_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready held after accept")
	`ASO_ASSERT_NOW(a_events_range, m_axis_tvalid, m_axis_tdata[33:32] != 2'b11, "clip event count out of range")
	`ASO_ASSERT_NOW(a_total_mid_frame, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[47:34] == '0, "frame total set before frame end")
	`ASO_ASSERT_NOW(a_total_cap, m_axis_tvalid, m_axis_tdata[47:34] <= TALLY_CAP, "frame total above cap")

endmodule

bind actuator_scale_offset_clip aso_checker u_aso_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

// ----- tb/tb_actuator_scale_offset_clip.sv -----
// Testbench for actuator_scale_offset_clip: directed table, then random frames in both modes.
`timescale 1ns / 100ps

module tb_actuator_scale_offset_clip;
	import aso_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SEG_ITEMS     = 270;
	localparam int SETTLE_CYCLES = 16;

	typedef struct {
		logic signed [31:0] demand;
		logic signed [31:0] gain;
		logic signed [31:0] bias;
		logic               sq;
		logic [15:0]        lo;
		logic [15:0]        hi;
		logic               fend;
	} act_item_t;

	typedef struct {
		logic [31:0] command;
		logic [1:0]  events;
		logic [13:0] total;
		logic        done;
	} cmd_word_t;

	typedef struct {
		logic      mode;
		act_item_t it;
		bit        typed;
		cmd_word_t want;
	} dir_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata;
	logic         s_axis_tlast;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [47:0]  m_axis_tdata;
	logic         m_axis_tlast;
	logic         cfg_we;
	logic         cfg_wdata;

	logic        out_mode;
	logic [13:0] clip_tally_m;
	cmd_word_t   pending_cmds[$];
	dir_row_t    dir_rows[$];
	int          errors;
	int          n_results;
	int          n_clipped;
	int          n_frames;
	int          n_sent;
	int          burst_left;
	longint      cyc_count;
	bit          hold_done;

	actuator_scale_offset_clip dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint sat32(input longint x);
		if (x > longint'(SAT_POS))
			return longint'(SAT_POS);
		if (x < longint'(SAT_NEG))
			return longint'(SAT_NEG);
		return x;
	endfunction

	// scale, offset, optional square, round/clamp; advances the frame tally
	function automatic cmd_word_t scale_clip_predict(input act_item_t it);
		cmd_word_t   res;
		longint      v;
		longint      t;
		longint      code;
		longint      lq;
		longint      hq;
		logic [1:0]  ev;
		int unsigned sum;
		v = sat32(((longint'(it.demand) * longint'(it.gain)) >>> 16) + longint'(it.bias));
		if (it.sq)
			v = sat32((v * v) >>> 16);
		ev = 2'd0;
		if (out_mode == MODE_CODE) begin
			t = v + 32768;
			if (t >= 0)
				code = t >>> 16;
			else
				code = -((-t) >>> 16);
			res.command = {16'h0, code[15:0]};
			if (code < longint'(it.lo)) begin
				ev++;
				res.command = {16'h0, it.lo};
			end
			if (code > longint'(it.hi)) begin
				ev++;
				res.command = {16'h0, it.hi};
			end
		end else begin
			lq = longint'(it.lo) * 65536;
			hq = longint'(it.hi) * 65536;
			t = v;
			if (v < lq) begin
				ev++;
				t = sat32(lq);
			end
			if (v > hq) begin
				ev++;
				t = sat32(hq);
			end
			res.command = t[31:0];
		end
		sum = clip_tally_m + ev;
		if (sum > TALLY_CAP)
			sum = TALLY_CAP;
		if (it.fend) begin
			res.total = sum[13:0];
			clip_tally_m = '0;
		end else begin
			res.total = '0;
			clip_tally_m = sum[13:0];
		end
		res.events = ev;
		res.done = it.fend;
		return res;
	endfunction

	function automatic act_item_t rand_item();
		act_item_t it;
		int        kind;
		kind = $urandom_range(0, 9);
		it.sq = ($urandom_range(0, 3) == 0);
		it.fend = ($urandom_range(0, 11) == 0);
		if (kind <= 5) begin
			// plausible operating point: gain near unity, limits bracketing the output
			it.demand = int'($urandom_range(0, 1 << 21)) - (1 << 20);
			it.gain = int'($urandom_range(0, 1 << 18)) - (1 << 17);
			it.bias = int'($urandom_range(0, 1 << 25)) - (1 << 24);
			it.lo = 16'($urandom_range(0, 64));
			it.hi = 16'(it.lo + $urandom_range(0, 300));
		end else if (kind <= 7) begin
			it.demand = $urandom();
			it.gain = $urandom();
			it.bias = $urandom();
			it.sq = 1'($urandom_range(0, 1));
			it.lo = 16'($urandom_range(0, 65535));
			it.hi = 16'($urandom_range(0, 65535));
			it.fend = 1'($urandom_range(0, 1));
		end else if (kind == 8) begin
			it.demand = int'($urandom_range(0, 1 << 25)) - (1 << 24);
			it.gain = 32'sh0001_0000;
			it.bias = int'($urandom_range(0, 1 << 24)) - (1 << 23);
			it.sq = 1'b1;
			it.lo = 16'($urandom_range(0, 65535));
			it.hi = 16'($urandom_range(0, 65535));
		end else begin
			// inverted limits
			it.demand = int'($urandom_range(0, 1 << 21)) - (1 << 20);
			it.gain = int'($urandom_range(0, 1 << 18)) - (1 << 17);
			it.bias = int'($urandom_range(0, 1 << 30));
			it.lo = 16'($urandom_range(1, 65535));
			it.hi = 16'($urandom_range(0, it.lo - 1));
		end
		return it;
	endfunction

	task automatic add_row(input logic mode, input logic [31:0] demand, input logic [31:0] gain,
			input logic [31:0] bias, input logic sq, input logic [15:0] lo, input logic [15:0] hi,
			input logic fend, input bit typed, input logic [31:0] cmd, input logic [1:0] ev,
			input logic [13:0] total);
		dir_row_t r;
		r.mode = mode;
		r.it.demand = demand;
		r.it.gain = gain;
		r.it.bias = bias;
		r.it.sq = sq;
		r.it.lo = lo;
		r.it.hi = hi;
		r.it.fend = fend;
		r.typed = typed;
		r.want.command = cmd;
		r.want.events = ev;
		r.want.total = total;
		r.want.done = fend;
		dir_rows.push_back(r);
	endtask

	// offer one word in bursts with random gaps; record the expectation on acceptance
	task automatic drive_item(input act_item_t it, input bit typed, input cmd_word_t want);
		cmd_word_t pred;
		int        gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tdata <= {7'd0, it.hi, it.lo, it.sq, it.bias, it.gain, it.demand};
		s_axis_tlast <= it.fend;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		pred = scale_clip_predict(it);
		if (typed)
			pending_cmds.push_back(want);
		else
			pending_cmds.push_back(pred);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic settle_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_mode(input logic m);
		settle_idle();
		cfg_wdata <= m;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		out_mode = m;
	endtask

	always @(posedge clk) begin : result_check
		cmd_word_t want;
		cmd_word_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.command = m_axis_tdata[31:0];
			got.events = m_axis_tdata[33:32];
			got.total = m_axis_tdata[47:34];
			got.done = m_axis_tlast;
			n_results++;
			if (got.events != 0)
				n_clipped++;
			if (got.done)
				n_frames++;
			if (pending_cmds.size() == 0) begin
				errors++;
				$display("%0t error: word with none expected, got %h last %b", $time,
					m_axis_tdata, m_axis_tlast);
			end else begin
				want = pending_cmds.pop_front();
				if (got.command !== want.command) begin
					errors++;
					$display("%0t error: command exp %h got %h", $time, want.command, got.command);
				end
				if (got.events !== want.events) begin
					errors++;
					$display("%0t error: clip_events exp %0d got %0d", $time, want.events,
						got.events);
				end
				if (got.total !== want.total) begin
					errors++;
					$display("%0t error: frame_clip_total exp %0d got %0d", $time, want.total,
						got.total);
				end
				if (got.done !== want.done) begin
					errors++;
					$display("%0t error: frame_done exp %b got %b", $time, want.done, got.done);
				end
			end
		end
	end

	always @(posedge clk) begin
		cyc_count++;
		if (cyc_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver: stall pattern steps through four settings chosen by rx_cyc[7:6], plus one long hold-off
	initial begin : receiver
		int   rx_cyc;
		logic rdy;
		m_axis_tready = 1'b0;
		rx_cyc = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			rx_cyc++;
			if (!hold_done && n_results >= 400) begin
				hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				case (rx_cyc[7:6])
					2'd0: rdy = 1'b1;
					2'd1: rdy = 1'($urandom_range(0, 1));
					2'd2: rdy = ($urandom_range(0, 3) != 0);
					default: rdy = ($urandom_range(0, 7) == 0);
				endcase
				m_axis_tready <= rdy;
			end
		end
	end

	initial begin : stimulus
		act_item_t it;
		cmd_word_t none;
		int        seg;
		int        k;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		out_mode = MODE_CODE;
		clip_tally_m = '0;
		errors = 0;
		n_results = 0;
		n_clipped = 0;
		n_frames = 0;
		n_sent = 0;
		burst_left = 0;
		cyc_count = 0;
		hold_done = 1'b0;
		none.command = '0;
		none.events = '0;
		none.total = '0;
		none.done = 1'b0;

		// integer codes
		add_row(MODE_CODE, 32'h0, 32'h0, 32'h0, 0, 16'd0, 16'd65535, 1, 1, 32'd0, 2'd0, 14'd0);
		add_row(MODE_CODE, 32'h0001_0000, 32'h0001_0000, 32'h0, 0, 16'd0, 16'd65535, 0,
			1, 32'd1, 2'd0, 14'd0);
		add_row(MODE_CODE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 16'd0, 16'd65535, 0,
			0, 0, 0, 0);
		add_row(MODE_CODE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 16'd0, 16'd65535, 0,
			0, 0, 0, 0);
		add_row(MODE_CODE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 16'd0, 16'd65535, 0,
			0, 0, 0, 0);
		add_row(MODE_CODE, 32'h0, 32'h0, 32'h0000_8000, 0, 16'd0, 16'd65535, 0, 0, 0, 0, 0);
		add_row(MODE_CODE, 32'h0, 32'h0, 32'hFFFF_8000, 0, 16'd0, 16'd65535, 0, 0, 0, 0, 0);
		add_row(MODE_CODE, 32'h0, 32'h0, 32'hFFFE_8000, 0, 16'd0, 16'd65535, 0, 0, 0, 0, 0);
		add_row(MODE_CODE, 32'hFFFF_FFFF, 32'h1, 32'h0, 0, 16'd0, 16'd65535, 0, 0, 0, 0, 0);
		add_row(MODE_CODE, 32'h0002_0000, 32'h0001_0000, 32'h0, 1, 16'd0, 16'd65535, 0,
			0, 0, 0, 0);
		add_row(MODE_CODE, 32'hFFFD_0000, 32'h0001_0000, 32'h0, 1, 16'd0, 16'd65535, 0,
			0, 0, 0, 0);
		add_row(MODE_CODE, 32'h0, 32'h0, 32'h0100_0000, 1, 16'd0, 16'd65535, 0, 0, 0, 0, 0);
		// limits crossed: the maximum wins and both hits count
		add_row(MODE_CODE, 32'h0, 32'h0, 32'h004B_0000, 0, 16'd100, 16'd50, 0,
			1, 32'd50, 2'd2, 14'd0);
		add_row(MODE_CODE, 32'h0, 32'h0, 32'h0064_0000, 0, 16'd0, 16'd10, 0, 0, 0, 0, 0);
		add_row(MODE_CODE, 32'h0, 32'h0, 32'h0, 0, 16'd65535, 16'd65535, 0, 0, 0, 0, 0);
		add_row(MODE_CODE, 32'h0, 32'h0, 32'h0, 0, 16'd0, 16'd0, 1, 0, 0, 0, 0);
		// fixed point
		add_row(MODE_FIXED, 32'h1234_5678, 32'h0001_0000, 32'h0, 0, 16'd0, 16'd65535, 0,
			0, 0, 0, 0);
		// a limit code past the Q16.16 range saturates once chosen
		add_row(MODE_FIXED, 32'h0, 32'h0, 32'h0, 0, 16'd40000, 16'd65535, 0,
			1, 32'h7FFF_FFFF, 2'd1, 14'd0);
		add_row(MODE_FIXED, 32'h0, 32'h0, 32'h0001_0000, 0, 16'd0, 16'd0, 0,
			1, 32'd0, 2'd1, 14'd0);
		add_row(MODE_FIXED, 32'h0, 32'h0, 32'h8000_0000, 0, 16'd0, 16'd65535, 0, 0, 0, 0, 0);
		add_row(MODE_FIXED, 32'h0, 32'h0, 32'h0001_0000, 0, 16'd65535, 16'd0, 0, 0, 0, 0, 0);
		add_row(MODE_FIXED, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0, 1, 16'd0, 16'd65535, 0,
			0, 0, 0, 0);
		add_row(MODE_FIXED, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 16'd65535,
			16'd65535, 1, 0, 0, 0, 0);

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].mode !== out_mode)
				set_mode(dir_rows[i].mode);
			drive_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
		end

		for (seg = 0; seg < 6; seg++) begin
			set_mode(seg[0] ? MODE_FIXED : MODE_CODE);
			for (k = 0; k < SEG_ITEMS; k++)
				drive_item(rand_item(), 1'b0, none);
		end

		// short closing frame
		for (k = 0; k < 12; k++) begin
			it = rand_item();
			it.fend = (k == 11);
			drive_item(it, 1'b0, none);
		end

		settle_idle();
		errors += pending_cmds.size();
		$display("Checked %0d results from %0d words in %0d frames, %0d of them clipped,",
			n_results, n_sent, n_frames, n_clipped);
		$display("in both output modes, with bursty input and a long output stall");
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/aso_pkg.sv
rtl/core/aso_mul.sv
rtl/core/aso_limit.sv
rtl/core/actuator_scale_offset_clip.sv
rtl/core/aso_checker.sv
tb/tb_actuator_scale_offset_clip.sv
